### rtl/sclp_pkg.sv
// Shared constants and types for the serial command line parser.
// Used by rtl/serial_command_line_parser.sv; no other dependencies.
package sclp_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] arg_phase_type;
   typedef logic [1:0] csr_index_type;

   // Argument scan phases after the keyword
   localparam arg_phase_type PHASE_SKIP   = 2'd0;
   localparam arg_phase_type PHASE_DIGITS = 2'd1;
   localparam arg_phase_type PHASE_DONE   = 2'd2;
   localparam arg_phase_type PHASE_NONE   = 2'd3;

   // Register indexes
   localparam csr_index_type CSR_DEFAULT_SCALE = 2'd0;
   localparam csr_index_type CSR_MIN_SCALE     = 2'd1;
   localparam csr_index_type CSR_MAX_SCALE     = 2'd2;

   localparam byte_type RESET_DEFAULT_SCALE = 8'd4;
   localparam byte_type RESET_MIN_SCALE     = 8'd1;
   localparam byte_type RESET_MAX_SCALE     = 8'd8;

   // Command kinds
   localparam logic KIND_PING = 1'b0;
   localparam logic KIND_SNAP = 1'b1;

   localparam byte_type CHAR_CR    = 8'h0D;
   localparam byte_type CHAR_LF    = 8'h0A;
   localparam byte_type CHAR_TAB   = 8'h09;
   localparam byte_type CHAR_SPACE = 8'h20;
   localparam byte_type CHAR_NUL   = 8'h00;
   localparam byte_type CHAR_ZERO  = 8'h30;
   localparam byte_type CHAR_NINE  = 8'h39;
   localparam byte_type SAT_MAX    = 8'hFF;

   localparam int KEYWORD_LEN = 4;

   localparam byte_type WORD_PING [KEYWORD_LEN] = '{8'h50, 8'h49, 8'h4E, 8'h47};
   localparam byte_type WORD_SNAP [KEYWORD_LEN] = '{8'h53, 8'h4E, 8'h41, 8'h50};

endpackage

### rtl/serial_command_line_parser.sv
// Serial command line parser: streams received bytes, emits ping/snap commands.
// Depends on rtl/sclp_pkg.sv for character codes, phases and register indexes.
//
// Usage:
//   req channel carries one received byte per word (req_tdata).
//   rsp channel carries one command per word: rsp_tuser = kind (0 ping, 1 snap),
//   rsp_tdata = scale. Only a newline that closes a PING or SNAP line gives a word.
//   csr port writes default_scale (0), min_scale (1), max_scale (2); write only
//   while no byte is in flight.
// Timing:
//   One byte per cycle sustained while rsp is not stalled, as the throughput is set
//   by the single line-state update per cycle. A byte is held in an input register;
//   the line state and result register are updated from it when the pipeline
//   advances, so a command is presented on rsp after its newline leaves the input register.
// Reset:
//   Synchronous, active high. Clears the line state, both word registers and
//   reloads the register defaults (4, 1, 8).
// Stall:
//   When rsp_tready is low with a command waiting, the pipeline holds and
//   req_tready drops once the input register is also occupied; nothing is lost.
module serial_command_line_parser #(
   parameter int LINE_CAPACITY = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] scale_value
   output logic [0:0] rsp_tuser,   // [0] command_kind
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int CW = $clog2(LINE_CAPACITY);
   localparam logic [CW-1:0] COUNT_LIMIT = CW'(LINE_CAPACITY - 1);
   localparam logic [CW-1:0] KEY_LEN     = CW'(sclp_pkg::KEYWORD_LEN);

   // configuration
   logic [7:0] default_scale_ff, min_scale_ff, max_scale_ff;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // line state
   logic [CW-1:0]           char_count_ff, char_count_in;
   logic                    ping_match_ff, ping_match_in;
   logic                    snap_match_ff, snap_match_in;
   logic                    ended_ff, ended_in;
   sclp_pkg::arg_phase_type phase_ff, phase_in;
   logic [7:0]              accum_ff, accum_in;

   // result register
   logic       out_valid_ff;
   logic       out_kind_ff, out_kind_in;
   logic [7:0] out_scale_ff, out_scale_in;
   logic       out_fire;

   logic advance;
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_scale_ff;
   assign rsp_tuser[0] = out_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_scale_ff <= sclp_pkg::RESET_DEFAULT_SCALE;
         min_scale_ff     <= sclp_pkg::RESET_MIN_SCALE;
         max_scale_ff     <= sclp_pkg::RESET_MAX_SCALE;
      end else if (csr_we) begin
         unique case (csr_index)
            sclp_pkg::CSR_DEFAULT_SCALE: default_scale_ff <= csr_wdata;
            sclp_pkg::CSR_MIN_SCALE:     min_scale_ff     <= csr_wdata;
            sclp_pkg::CSR_MAX_SCALE:     max_scale_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   logic        is_digit, is_blank;
   logic [3:0]  digit_val;
   logic [11:0] accum_next;
   logic [7:0]  bounded;

   always_comb begin
      is_digit   = (in_byte_ff >= sclp_pkg::CHAR_ZERO) && (in_byte_ff <= sclp_pkg::CHAR_NINE);
      is_blank   = (in_byte_ff == sclp_pkg::CHAR_SPACE) || (in_byte_ff == sclp_pkg::CHAR_TAB);
      digit_val  = 4'(in_byte_ff - sclp_pkg::CHAR_ZERO);
      accum_next = 12'(accum_ff) * 12'd10 + 12'(digit_val);

      // lower bound checked first, so with min above max a value below min yields min and any other yields max
      if (accum_ff < min_scale_ff) begin
         bounded = min_scale_ff;
      end else if (accum_ff > max_scale_ff) begin
         bounded = max_scale_ff;
      end else begin
         bounded = accum_ff;
      end

      char_count_in = char_count_ff;
      ping_match_in = ping_match_ff;
      snap_match_in = snap_match_ff;
      ended_in      = ended_ff;
      phase_in      = phase_ff;
      accum_in      = accum_ff;
      out_fire      = 1'b0;
      out_kind_in   = sclp_pkg::KIND_PING;
      out_scale_in  = default_scale_ff;

      if (in_byte_ff == sclp_pkg::CHAR_CR) begin
         // ignored
      end else if (in_byte_ff == sclp_pkg::CHAR_LF || char_count_ff >= COUNT_LIMIT) begin
         if (in_byte_ff == sclp_pkg::CHAR_LF && char_count_ff >= KEY_LEN) begin
            if (ping_match_ff) begin
               out_fire = 1'b1;
            end else if (snap_match_ff) begin
               out_fire    = 1'b1;
               out_kind_in = sclp_pkg::KIND_SNAP;
               if (phase_ff == sclp_pkg::PHASE_DIGITS || phase_ff == sclp_pkg::PHASE_DONE) begin
                  out_scale_in = bounded;
               end
            end
         end
         // end of line or overflow: back to an empty line
         char_count_in = '0;
         ping_match_in = 1'b1;
         snap_match_in = 1'b1;
         ended_in      = 1'b0;
         phase_in      = sclp_pkg::PHASE_SKIP;
         accum_in      = '0;
      end else begin
         char_count_in = char_count_ff + 1'b1;
         if (!ended_ff) begin
            if (char_count_ff < KEY_LEN) begin
               if (in_byte_ff != sclp_pkg::WORD_PING[char_count_ff[1:0]]) begin
                  ping_match_in = 1'b0;
               end
               if (in_byte_ff != sclp_pkg::WORD_SNAP[char_count_ff[1:0]]) begin
                  snap_match_in = 1'b0;
               end
               if (in_byte_ff == sclp_pkg::CHAR_NUL) begin
                  ended_in = 1'b1;
               end
            end else if (in_byte_ff == sclp_pkg::CHAR_NUL) begin
               ended_in = 1'b1;
               if (phase_ff == sclp_pkg::PHASE_SKIP) begin
                  phase_in = sclp_pkg::PHASE_NONE;
               end else if (phase_ff == sclp_pkg::PHASE_DIGITS) begin
                  phase_in = sclp_pkg::PHASE_DONE;
               end
            end else if (phase_ff == sclp_pkg::PHASE_SKIP) begin
               if (is_digit) begin
                  accum_in = 8'(digit_val);
                  phase_in = sclp_pkg::PHASE_DIGITS;
               end else if (!is_blank) begin
                  phase_in = sclp_pkg::PHASE_NONE;
               end
            end else if (phase_ff == sclp_pkg::PHASE_DIGITS) begin
               if (is_digit) begin
                  accum_in = (accum_next > 12'(sclp_pkg::SAT_MAX)) ? sclp_pkg::SAT_MAX
                                                                  : accum_next[7:0];
               end else begin
                  phase_in = sclp_pkg::PHASE_DONE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= '0;
         ping_match_ff <= 1'b1;
         snap_match_ff <= 1'b1;
         ended_ff      <= 1'b0;
         phase_ff      <= sclp_pkg::PHASE_SKIP;
         accum_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff && out_fire;
         if (in_valid_ff) begin
            char_count_ff <= char_count_in;
            ping_match_ff <= ping_match_in;
            snap_match_ff <= snap_match_in;
            ended_ff      <= ended_in;
            phase_ff      <= phase_in;
            accum_ff      <= accum_in;
         end
      end
      if (advance && in_valid_ff && out_fire) begin
         out_kind_ff  <= out_kind_in;
         out_scale_ff <= out_scale_in;
      end
   end

endmodule

### test/tb_serial_command_line_parser.sv
// Self-checking testbench for serial_command_line_parser: streams byte lines,
// predicts ping/snap commands and checks every result word.
// Depends on rtl/sclp_pkg.sv and rtl/serial_command_line_parser.sv.
`timescale 1ns / 1ps

module tb_serial_command_line_parser;

   localparam int LINE_CAPACITY = 32;
   localparam int DRAIN_CYCLES  = 8;
   localparam int QUIET_LIMIT   = 1000;
   localparam int HOLD_OFF_LEN  = 80;

   typedef struct packed {
      logic               kind;
      sclp_pkg::byte_type scale;
   } command_word_type;

   // Line-state predictor plus the queue of commands still owed by the block
   class command_tracker_type;
      sclp_pkg::byte_type      default_scale;
      sclp_pkg::byte_type      min_scale;
      sclp_pkg::byte_type      max_scale;
      int                      line_len;
      bit                      ping_ok;
      bit                      snap_ok;
      bit                      nul_seen;
      sclp_pkg::arg_phase_type arg_phase;
      sclp_pkg::byte_type      arg_value;
      command_word_type        pending_commands[$];
      int                      mismatches;

      function new();
         default_scale = sclp_pkg::RESET_DEFAULT_SCALE;
         min_scale     = sclp_pkg::RESET_MIN_SCALE;
         max_scale     = sclp_pkg::RESET_MAX_SCALE;
         mismatches    = 0;
         clear_line();
      endfunction

      function void clear_line();
         line_len  = 0;
         ping_ok   = 1'b1;
         snap_ok   = 1'b1;
         nul_seen  = 1'b0;
         arg_phase = sclp_pkg::PHASE_SKIP;
         arg_value = '0;
      endfunction

      function void set_reg(sclp_pkg::csr_index_type idx, sclp_pkg::byte_type value);
         case (idx)
            sclp_pkg::CSR_DEFAULT_SCALE: default_scale = value;
            sclp_pkg::CSR_MIN_SCALE:     min_scale = value;
            sclp_pkg::CSR_MAX_SCALE:     max_scale = value;
            default: ;
         endcase
      endfunction

      function void take_byte(sclp_pkg::byte_type b);
         int               v;
         command_word_type cmd;
         bit               digit;
         digit = (b >= sclp_pkg::CHAR_ZERO && b <= sclp_pkg::CHAR_NINE);
         if (b == sclp_pkg::CHAR_CR)
            return;
         if (b == sclp_pkg::CHAR_LF) begin
            if (line_len >= sclp_pkg::KEYWORD_LEN && (ping_ok || snap_ok)) begin
               cmd.kind  = ping_ok ? sclp_pkg::KIND_PING : sclp_pkg::KIND_SNAP;
               cmd.scale = default_scale;
               if (!ping_ok && (arg_phase == sclp_pkg::PHASE_DIGITS ||
                                arg_phase == sclp_pkg::PHASE_DONE)) begin
                  // lower bound checked first: with min above max, below min gives min, else max
                  if (arg_value < min_scale)
                     cmd.scale = min_scale;
                  else if (arg_value > max_scale)
                     cmd.scale = max_scale;
                  else
                     cmd.scale = arg_value;
               end
               pending_commands.push_back(cmd);
            end
            clear_line();
            return;
         end
         if (line_len + 1 >= LINE_CAPACITY) begin
            // line full: this byte is dropped
            clear_line();
            return;
         end
         if (!nul_seen) begin
            if (line_len < sclp_pkg::KEYWORD_LEN) begin
               if (b != sclp_pkg::WORD_PING[line_len])
                  ping_ok = 1'b0;
               if (b != sclp_pkg::WORD_SNAP[line_len])
                  snap_ok = 1'b0;
               if (b == sclp_pkg::CHAR_NUL)
                  nul_seen = 1'b1;
            end else if (b == sclp_pkg::CHAR_NUL) begin
               nul_seen = 1'b1;
               if (arg_phase == sclp_pkg::PHASE_SKIP)
                  arg_phase = sclp_pkg::PHASE_NONE;
               else if (arg_phase == sclp_pkg::PHASE_DIGITS)
                  arg_phase = sclp_pkg::PHASE_DONE;
            end else if (arg_phase == sclp_pkg::PHASE_SKIP) begin
               if (digit) begin
                  arg_value = b - sclp_pkg::CHAR_ZERO;
                  arg_phase = sclp_pkg::PHASE_DIGITS;
               end else if (b != sclp_pkg::CHAR_SPACE && b != sclp_pkg::CHAR_TAB) begin
                  arg_phase = sclp_pkg::PHASE_NONE;
               end
            end else if (arg_phase == sclp_pkg::PHASE_DIGITS) begin
               if (digit) begin
                  v = int'(arg_value) * 10 + int'(b) - int'(sclp_pkg::CHAR_ZERO);
                  arg_value = (v > 255) ? sclp_pkg::SAT_MAX : sclp_pkg::byte_type'(v);
               end else begin
                  arg_phase = sclp_pkg::PHASE_DONE;
               end
            end
         end
         line_len++;
      endfunction

      function void match_command(logic kind, sclp_pkg::byte_type scale);
         command_word_type cmd;
         if (pending_commands.size() == 0) begin
            $display("%0t: unexpected command: kind %0d scale %0d", $time, kind, scale);
            mismatches++;
         end else begin
            cmd = pending_commands.pop_front();
            if (cmd.kind !== kind) begin
               $display("%0t: kind mismatch: expected %0d, actual %0d", $time, cmd.kind, kind);
               mismatches++;
            end
            if (cmd.scale !== scale) begin
               $display("%0t: scale mismatch: expected %0d, actual %0d",
                        $time, cmd.scale, scale);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;    // [7:0] rx_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // [7:0] scale_value
   logic [0:0] rsp_tuser;         // [0] command_kind
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   command_tracker_type tracker;
   sclp_pkg::byte_type  line_bytes[$];
   int                  bytes_sent = 0;
   bit                  src_stall_en = 1'b1;
   bit                  sink_stall_en = 1'b1;
   bit                  hold_off_pending = 1'b0;
   int                  hold_left = 0;
   int                  quiet_cycles = 0;

   serial_command_line_parser #(.LINE_CAPACITY(LINE_CAPACITY)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // result side: check accepted words, then pick tready for the next edge
   always @(posedge clock) begin
      if (!reset && tracker != null && rsp_tvalid && rsp_tready)
         tracker.match_command(rsp_tuser[0], rsp_tdata);
      if (hold_off_pending) begin
         hold_off_pending = 1'b0;
         hold_left = HOLD_OFF_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(sink_stall_en && $urandom_range(0, 99) < 20);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_byte(input sclp_pkg::byte_type b);
      while (src_stall_en && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do
         @(posedge clock);
      while (!req_tready);
      tracker.take_byte(b);
      if (b != sclp_pkg::CHAR_CR)
         bytes_sent++;
   endtask

   // sends the queued line, with a stray CR now and then
   task automatic send_line();
      int i;
      for (i = 0; i < line_bytes.size(); i++) begin
         if ($urandom_range(0, 99) < 3)
            send_byte(sclp_pkg::CHAR_CR);
         send_byte(line_bytes[i]);
      end
      line_bytes.delete();
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         line_bytes.push_back(sclp_pkg::byte_type'(s[i]));
   endtask

   task automatic send_text(input string s);
      add_text(s);
      send_line();
   endtask

   task automatic add_junk();
      int n;
      int i;
      n = $urandom_range(0, 9);
      if (n < 3) begin
         for (i = 0; i <= n; i++)
            line_bytes.push_back(sclp_pkg::byte_type'($urandom_range(0, 255)));
      end else if (n == 3) begin
         line_bytes.push_back(sclp_pkg::CHAR_NUL);
         line_bytes.push_back(sclp_pkg::CHAR_ZERO + sclp_pkg::byte_type'($urandom_range(0, 9)));
      end
   endtask

   task automatic send_random_line();
      int pick;
      int n;
      int i;
      int which;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         add_text("SNAP");
         n = $urandom_range(0, 3);
         for (i = 0; i < n; i++)
            line_bytes.push_back($urandom_range(0, 1) ? sclp_pkg::CHAR_SPACE
                                                      : sclp_pkg::CHAR_TAB);
         if ($urandom_range(0, 4) != 0) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
               line_bytes.push_back(sclp_pkg::CHAR_ZERO +
                                    sclp_pkg::byte_type'($urandom_range(0, 9)));
         end
         add_junk();
      end else if (pick < 55) begin
         add_text("PING");
         add_junk();
      end else if (pick < 70) begin
         // keyword with one bad byte, or cut short
         which = $urandom_range(0, 1);
         n = $urandom_range(0, sclp_pkg::KEYWORD_LEN - 1);
         for (i = 0; i < sclp_pkg::KEYWORD_LEN; i++) begin
            if (i == n)
               line_bytes.push_back(sclp_pkg::byte_type'($urandom_range(0, 255)));
            else
               line_bytes.push_back(which ? sclp_pkg::WORD_SNAP[i] : sclp_pkg::WORD_PING[i]);
         end
         if ($urandom_range(0, 1))
            line_bytes = line_bytes[0:n];
         add_junk();
      end else if (pick < 88) begin
         n = $urandom_range(0, 12);
         for (i = 0; i < n; i++)
            line_bytes.push_back(sclp_pkg::byte_type'($urandom_range(0, 255)));
      end else begin
         // around the line capacity
         add_text("SNAP ");
         n = $urandom_range(LINE_CAPACITY - 8, LINE_CAPACITY + 4);
         for (i = 0; i < n; i++)
            line_bytes.push_back(sclp_pkg::CHAR_ZERO +
                                 sclp_pkg::byte_type'($urandom_range(0, 9)));
      end
      line_bytes.push_back(sclp_pkg::CHAR_LF);
      send_line();
   endtask

   task automatic run_random(input int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target)
         send_random_line();
   endtask

   // writes only once every owed command is out and the pipeline has drained
   task automatic write_reg(input sclp_pkg::csr_index_type idx,
                            input sclp_pkg::byte_type value);
      req_tvalid <= 1'b0;
      while (tracker.pending_commands.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_reg(idx, value);
   endtask

   initial begin
      sclp_pkg::byte_type lo;
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_text("PING\n");
      send_text("SNAP\n");
      send_text("SNAP \t42\n");
      send_text("SNAP 0\n");
      send_text("SNAP 999x\n");
      send_text("SNAPxy 3\n");
      send_text("PIN\n");
      send_text("\n");
      add_text("P");
      line_bytes.push_back(sclp_pkg::CHAR_NUL);
      send_text("NG\n");
      add_text("SNAP 3");
      line_bytes.push_back(sclp_pkg::CHAR_NUL);
      send_text("7\n");
      add_text("SNAP ");
      line_bytes.push_back(sclp_pkg::CHAR_NUL);
      send_text("5\n");
      send_text("PI\rNG\r\n");
      line_bytes.push_back(8'hFF);
      line_bytes.push_back(8'h80);
      line_bytes.push_back(8'h7F);
      send_text("\n");
      // full line, then one byte that overflows it
      send_text("SNAP 6zzzzzzzzzzzzzzzzzzzzzzzzzQ");
      send_text("SNAP 2\n");

      write_reg(sclp_pkg::CSR_DEFAULT_SCALE, 8'd0);
      write_reg(sclp_pkg::CSR_MIN_SCALE, 8'd0);
      write_reg(sclp_pkg::CSR_MAX_SCALE, 8'd255);
      run_random(80);

      // min above max; no stalls on either side for this stretch
      write_reg(sclp_pkg::CSR_DEFAULT_SCALE, 8'd255);
      write_reg(sclp_pkg::CSR_MIN_SCALE, 8'd200);
      write_reg(sclp_pkg::CSR_MAX_SCALE, 8'd100);
      src_stall_en  = 1'b0;
      sink_stall_en = 1'b0;
      run_random(80);
      src_stall_en  = 1'b1;
      sink_stall_en = 1'b1;

      lo = sclp_pkg::byte_type'($urandom_range(0, 127));
      write_reg(sclp_pkg::CSR_DEFAULT_SCALE, sclp_pkg::byte_type'($urandom_range(0, 255)));
      write_reg(sclp_pkg::CSR_MIN_SCALE, lo);
      write_reg(sclp_pkg::CSR_MAX_SCALE, sclp_pkg::byte_type'($urandom_range(lo, 255)));
      hold_off_pending = 1'b1;
      run_random(80);

      write_reg(sclp_pkg::CSR_DEFAULT_SCALE, sclp_pkg::byte_type'($urandom_range(0, 255)));
      write_reg(sclp_pkg::CSR_MIN_SCALE, sclp_pkg::byte_type'($urandom_range(0, 255)));
      write_reg(sclp_pkg::CSR_MAX_SCALE, sclp_pkg::byte_type'($urandom_range(0, 255)));
      run_random(90);

      req_tvalid <= 1'b0;
      while (tracker.pending_commands.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.pending_commands.size() != 0) begin
         $display("%0t: %0d commands never arrived", $time, tracker.pending_commands.size());
         tracker.mismatches++;
      end
      if (tracker.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
